FILE: src/hidm_pkg.sv
`timescale 1ns / 1ps
package hidm_pkg;

  localparam int NUM_BUTTONS_DEF = 36;
  localparam int BTN_W           = 36;
  localparam int ACC_W           = 11;

  localparam logic [10:0] MOVE_DIV     = 11'd50;
  localparam logic [10:0] WHEEL_DIV    = 11'd1000;
  localparam logic [2:0]  RESEND_COUNT = 3'd5;
  localparam logic [7:0]  AXIS_CENTER  = 8'h80;
  localparam logic [7:0]  AXIS_MAX     = 8'hff;

  // mapping kinds
  localparam logic [7:0] KIND_MOUSE    = 8'd0;
  localparam logic [7:0] KIND_KEYBOARD = 8'd1;
  localparam logic [7:0] KIND_JOYSTICK = 8'd2;

  // mouse action codes
  localparam logic [7:0] MACT_LEFT      = 8'd0;
  localparam logic [7:0] MACT_RIGHT     = 8'd1;
  localparam logic [7:0] MACT_MIDDLE    = 8'd2;
  localparam logic [7:0] MACT_UP        = 8'd3;
  localparam logic [7:0] MACT_DOWN      = 8'd4;
  localparam logic [7:0] MACT_LEFT_MOV  = 8'd5;
  localparam logic [7:0] MACT_RIGHT_MOV = 8'd6;
  localparam logic [7:0] MACT_WHEEL_UP  = 8'd7;
  localparam logic [7:0] MACT_WHEEL_DN  = 8'd8;
  localparam logic [7:0] MACT_ALL_SPEED = 8'd9;

  // report kinds
  localparam logic [1:0] REP_MOUSE    = 2'd0;
  localparam logic [1:0] REP_KEYBOARD = 2'd1;
  localparam logic [1:0] REP_JOYSTICK = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_MOTION,
    ST_EMIT
  } back_state_t;

  typedef struct packed {
    logic             mode;
    logic [BTN_W-1:0] buttons;
    logic             mouse_ready;
    logic             keyboard_ready;
    logic             joystick_ready;
    logic [5:0]       entry_index;
    logic [7:0]       entry_kind;
    logic [7:0]       entry_value;
    logic [7:0]       entry_modifier;
  } in_word_t;

  typedef struct packed {
    logic [1:0] report_kind;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
    logic [7:0] byte3;
    logic [7:0] byte4;
    logic [7:0] byte5;
    logic [7:0] byte6;
    logic [7:0] byte7;
    logic       last;
  } out_word_t;

  // classified item handed from front to back
  typedef struct packed {
    logic     scan;
    logic     wr_ok;
    in_word_t w;
  } q_item_t;

endpackage

FILE: src/hidm_front.sv
`timescale 1ns / 1ps
module hidm_front #(
  parameter int NUM_BUTTONS = hidm_pkg::NUM_BUTTONS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hidm_pkg::in_word_t in_data,
  output logic               q_valid,
  output hidm_pkg::q_item_t  q_item,
  input  logic               q_pop
);

  hidm_pkg::q_item_t buf_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  hidm_pkg::q_item_t item;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = buf_r[rp_r];

  // classify the incoming word
  always_comb begin
    item       = '0;
    item.w     = in_data;
    item.scan  = in_data.mode;
    item.wr_ok = (in_data.entry_index < 6'(NUM_BUTTONS));
  end

  // advance pointers and count
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = q_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // hold queued words
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= item;
    end
  end

endmodule

FILE: src/hidm_back.sv
`timescale 1ns / 1ps
module hidm_back #(
  parameter int NUM_BUTTONS = hidm_pkg::NUM_BUTTONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  hidm_pkg::q_item_t   q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output hidm_pkg::out_word_t out_data
);

  localparam int IW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int CW = $clog2(NUM_BUTTONS + 1);
  localparam logic [CW-1:0] LAST_CNT = CW'(NUM_BUTTONS);
  localparam int ACC_W_L = hidm_pkg::ACC_W;

  hidm_pkg::back_state_t st_r, st_nxt;

  // mapping table
  logic [23:0]            mem [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] vld_r;
  logic [23:0]            rd_r;
  logic                   rv_r, pp_r;
  logic                   wr_en;

  hidm_pkg::in_word_t cur_r;
  logic [CW-1:0] cnt_r;
  logic [2:0]    mcnt_r;
  logic [1:0]    ph_r;

  logic [5:0]       active_r;
  logic [7:0]       speed_r [4];
  logic [7:0]       wspd_r [2];
  logic [2:0]       clicks_r;
  logic [7:0]       kp_r [8];
  logic [7:0]       jp_r [4];
  logic [2:0]       rc_r [3];
  logic [3:0]       slot_r;
  logic [ACC_W_L-1:0] acc_r [6];
  logic [7:0]       rep_r [4];

  hidm_pkg::out_word_t out_r;
  logic                out_v_r;
  logic                out_load;

  // entry being processed
  logic [23:0] ent;
  logic [7:0]  e_kind, e_val, e_mod;

  // motion step
  logic [7:0]         spd;
  logic [ACC_W_L-1:0] sum, rem, lim;
  logic [2:0]         q;
  logic [7:0]         qb;
  logic               fire, neg;
  logic [1:0]         tgt;

  // emit control
  logic [2:0] rdy, em;
  logic       k_rdy, k_em, later, out_free, emit_go;

  assign out_valid = out_v_r;
  assign out_data  = out_r;
  assign out_free  = !out_v_r || out_ready;
  assign out_load  = (st_r == hidm_pkg::ST_EMIT) && emit_go && k_em;

  assign ent    = rv_r ? rd_r : 24'd0;
  assign e_kind = ent[7:0];
  assign e_val  = ent[15:8];
  assign e_mod  = ent[23:16];

  // motion arithmetic for direction mcnt_r
  always_comb begin
    spd = (mcnt_r < 3'd4) ? speed_r[mcnt_r[1:0]] : wspd_r[mcnt_r[0]];
    lim = (mcnt_r < 3'd4) ? hidm_pkg::MOVE_DIV : hidm_pkg::WHEEL_DIV;
    sum = acc_r[mcnt_r] + ACC_W_L'(spd);
    fire = active_r[mcnt_r] && (sum > lim);
    if (mcnt_r < 3'd4) begin
      q = 3'(sum >= 11'd50) + 3'(sum >= 11'd100) + 3'(sum >= 11'd150)
        + 3'(sum >= 11'd200) + 3'(sum >= 11'd250) + 3'(sum >= 11'd300);
      rem = sum - ACC_W_L'(q) * hidm_pkg::MOVE_DIV;
    end else begin
      q   = 3'd1;
      rem = sum - hidm_pkg::WHEEL_DIV;
    end
    neg = (mcnt_r == 3'd0) || (mcnt_r == 3'd2) || (mcnt_r == 3'd5);
    qb  = neg ? (8'd0 - 8'(q)) : 8'(q);
    case (mcnt_r)
      3'd0, 3'd1: tgt = 2'd2;
      3'd2, 3'd3: tgt = 2'd1;
      default:    tgt = 2'd3;
    endcase
  end

  // emit decisions for the current phase
  always_comb begin
    rdy = {cur_r.joystick_ready, cur_r.keyboard_ready, cur_r.mouse_ready};
    for (int k = 0; k < 3; k++) begin
      em[k] = rdy[k] && (rc_r[k] != 3'd0);
    end
    k_rdy = rdy[ph_r];
    k_em  = em[ph_r];
    case (ph_r)
      2'd0:    later = em[1] || em[2];
      2'd1:    later = em[2];
      default: later = 1'b0;
    endcase
    emit_go = !k_em || out_free;
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      hidm_pkg::ST_IDLE: begin
        if (q_valid && q_item.scan) st_nxt = hidm_pkg::ST_WALK;
      end
      hidm_pkg::ST_WALK: begin
        if (cnt_r == LAST_CNT) begin
          st_nxt = cur_r.mouse_ready ? hidm_pkg::ST_MOTION : hidm_pkg::ST_EMIT;
        end
      end
      hidm_pkg::ST_MOTION: begin
        if (mcnt_r == 3'd5) st_nxt = hidm_pkg::ST_EMIT;
      end
      hidm_pkg::ST_EMIT: begin
        if (emit_go && ph_r == 2'd2) st_nxt = hidm_pkg::ST_IDLE;
      end
      default: st_nxt = hidm_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    q_pop = 1'b0;
    wr_en = 1'b0;
    unique case (st_r)
      hidm_pkg::ST_IDLE: begin
        q_pop = q_valid;
        wr_en = q_valid && !q_item.scan && q_item.wr_ok;
      end
      default: begin
        q_pop = 1'b0;
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= hidm_pkg::ST_IDLE;
    else        st_r <= st_nxt;
  end

  // table memory: write one entry, read one per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[q_item.w.entry_index[IW-1:0]] <=
        {q_item.w.entry_modifier, q_item.w.entry_value, q_item.w.entry_kind};
    end
    rd_r <= mem[cnt_r[IW-1:0]];
  end

  // entry valid bits: unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_en) begin
      vld_r[q_item.w.entry_index[IW-1:0]] <= 1'b1;
    end
  end

  // hold the output word until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_load) begin
      out_v_r <= 1'b1;
    end else if (out_ready) begin
      out_v_r <= 1'b0;
    end
  end

  // walk, motion and emit datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
      clicks_r <= '0;
      slot_r   <= 4'd2;
      pp_r     <= 1'b0;
      rv_r     <= 1'b0;
      cnt_r    <= '0;
      mcnt_r   <= '0;
      ph_r     <= '0;
      for (int i = 0; i < 4; i++) begin
        speed_r[i] <= '0;
        rep_r[i]   <= '0;
        jp_r[i]    <= (i >= 2) ? hidm_pkg::AXIS_CENTER : 8'd0;
      end
      for (int i = 0; i < 2; i++) wspd_r[i] <= '0;
      for (int i = 0; i < 8; i++) kp_r[i] <= '0;
      for (int i = 0; i < 3; i++) rc_r[i] <= '0;
      for (int i = 0; i < 6; i++) acc_r[i] <= '0;
    end else begin
      unique case (st_r)
        hidm_pkg::ST_IDLE: begin
          // start a scan
          if (q_valid && q_item.scan) begin
            cur_r    <= q_item.w;
            active_r <= '0;
            slot_r   <= 4'd2;
            cnt_r    <= '0;
            mcnt_r   <= '0;
            ph_r     <= '0;
            pp_r     <= 1'b0;
            for (int i = 0; i < 4; i++) begin
              speed_r[i] <= '0;
              rep_r[i]   <= '0;
            end
          end
        end
        hidm_pkg::ST_WALK: begin
          // issue next read
          if (cnt_r != LAST_CNT) begin
            pp_r  <= cur_r.buttons[cnt_r[IW-1:0]];
            rv_r  <= vld_r[cnt_r[IW-1:0]];
            cnt_r <= cnt_r + 1'b1;
          end else begin
            pp_r <= 1'b0;
          end
          // apply the entry read last cycle
          if (pp_r) begin
            if (e_kind == hidm_pkg::KIND_MOUSE) begin
              if (e_val <= hidm_pkg::MACT_MIDDLE) begin
                clicks_r[e_val[1:0]] <= 1'b1;
              end else if (e_val <= hidm_pkg::MACT_RIGHT_MOV) begin
                active_r[3'(e_val - hidm_pkg::MACT_UP)] <= 1'b1;
                if (speed_r[2'(e_val - hidm_pkg::MACT_UP)] == 8'd0)
                  speed_r[2'(e_val - hidm_pkg::MACT_UP)] <= e_mod;
              end else if (e_val <= hidm_pkg::MACT_WHEEL_DN) begin
                active_r[3'(e_val - hidm_pkg::MACT_UP)] <= 1'b1;
                wspd_r[~e_val[0]] <= e_mod;
              end else if (e_val == hidm_pkg::MACT_ALL_SPEED) begin
                for (int i = 0; i < 4; i++) speed_r[i] <= e_mod;
              end
              rc_r[0] <= hidm_pkg::RESEND_COUNT;
            end else if (e_kind == hidm_pkg::KIND_KEYBOARD) begin
              if (!slot_r[3]) begin
                kp_r[0]           <= kp_r[0] | e_mod;
                kp_r[slot_r[2:0]] <= e_val;
                slot_r            <= slot_r + 4'd1;
              end
              rc_r[1] <= hidm_pkg::RESEND_COUNT;
            end else if (e_kind == hidm_pkg::KIND_JOYSTICK) begin
              if (e_val[1])      jp_r[3] <= hidm_pkg::AXIS_MAX;
              else if (e_val[0]) jp_r[3] <= 8'd0;
              if (e_val[3])      jp_r[2] <= hidm_pkg::AXIS_MAX;
              else if (e_val[2]) jp_r[2] <= 8'd0;
              jp_r[0] <= jp_r[0] | e_mod;
              jp_r[1] <= jp_r[1] | {4'd0, e_val[7:4]};
              rc_r[2] <= hidm_pkg::RESEND_COUNT;
            end
          end
        end
        hidm_pkg::ST_MOTION: begin
          // one direction per cycle
          acc_r[mcnt_r] <= active_r[mcnt_r] ? (fire ? rem : sum) : '0;
          if (fire) rep_r[tgt] <= qb;
          mcnt_r <= mcnt_r + 3'd1;
        end
        hidm_pkg::ST_EMIT: begin
          if (emit_go) begin
            if (k_rdy) begin
              case (ph_r)
                2'd0: clicks_r <= '0;
                2'd1: for (int i = 0; i < 8; i++) kp_r[i] <= '0;
                default: begin
                  jp_r[0] <= '0;
                  jp_r[1] <= '0;
                  jp_r[2] <= hidm_pkg::AXIS_CENTER;
                  jp_r[3] <= hidm_pkg::AXIS_CENTER;
                end
              endcase
            end
            if (k_em) begin
              rc_r[ph_r] <= rc_r[ph_r] - 3'd1;
              out_r.last <= !later;
              case (ph_r)
                2'd0: begin
                  out_r.report_kind <= hidm_pkg::REP_MOUSE;
                  out_r.byte0 <= {5'd0, clicks_r};
                  out_r.byte1 <= rep_r[1];
                  out_r.byte2 <= rep_r[2];
                  out_r.byte3 <= rep_r[3];
                  out_r.byte4 <= '0;
                  out_r.byte5 <= '0;
                  out_r.byte6 <= '0;
                  out_r.byte7 <= '0;
                end
                2'd1: begin
                  out_r.report_kind <= hidm_pkg::REP_KEYBOARD;
                  out_r.byte0 <= kp_r[0];
                  out_r.byte1 <= kp_r[1];
                  out_r.byte2 <= kp_r[2];
                  out_r.byte3 <= kp_r[3];
                  out_r.byte4 <= kp_r[4];
                  out_r.byte5 <= kp_r[5];
                  out_r.byte6 <= kp_r[6];
                  out_r.byte7 <= kp_r[7];
                end
                default: begin
                  out_r.report_kind <= hidm_pkg::REP_JOYSTICK;
                  out_r.byte0 <= jp_r[0];
                  out_r.byte1 <= jp_r[1];
                  out_r.byte2 <= jp_r[2];
                  out_r.byte3 <= jp_r[3];
                  out_r.byte4 <= '0;
                  out_r.byte5 <= '0;
                  out_r.byte6 <= '0;
                  out_r.byte7 <= '0;
                end
              endcase
            end
            ph_r <= ph_r + 2'd1;
          end
        end
        default: begin
          pp_r <= 1'b0;
        end
      endcase
    end
  end

endmodule

FILE: src/button_to_hid_report_mapper_top.sv
`timescale 1ns / 1ps
// A table write is applied in the back end; a scan walks the table (one entry per
// cycle, one read port), steps the six motion directions when the mouse is ready,
// then runs the mouse, keyboard and joystick report phases, which can stall on output.
// A new scan starts only when the back end is idle; a 2-word queue decouples input.
// Reset (rst_n low, synchronous) clears control state; table entries read zero until written.
module button_to_hid_report_mapper_top #(
  parameter int NUM_BUTTONS = hidm_pkg::NUM_BUTTONS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  hidm_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output hidm_pkg::out_word_t out_data
);

  logic              q_valid, q_pop;
  hidm_pkg::q_item_t q_item;

  hidm_front #(.NUM_BUTTONS(NUM_BUTTONS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  hidm_back #(.NUM_BUTTONS(NUM_BUTTONS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
